// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in any cycle implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and arithmetic helpers for the compensation block
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam logic [31:0] FINE_OFFSET  = 32'd64000;
    localparam logic [31:0] PRES_FULL    = 32'd1048576;
    localparam logic [31:0] PRES_SCALE   = 32'd3125;
    localparam logic [31:0] P1_BIAS      = 32'd32768;
    localparam logic [31:0] TEMP_ROUND   = 32'd128;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

    localparam int DIV_STEPS = 32;

    // register indexes of the configuration port
    localparam logic [1:0] REG_CAL_TEMP      = 2'd0;
    localparam logic [1:0] REG_CAL_PRES_LOW  = 2'd1;
    localparam logic [1:0] REG_CAL_PRES_HIGH = 2'd2;
    localparam logic [1:0] REG_CAL_PRES_NINE = 2'd3;

    // calibration coefficients, widened to 32 bits
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } ptc_coef_t;

    // work handed from the front to the divider side
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic        dbl;
        logic        invalid;
    } ptc_item_t;

    // one stage of the restoring divider
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] dq;
        logic [31:0] divisor;
        logic [31:0] temp;
        logic [31:0] fine;
        logic        dbl;
        logic        invalid;
    } ptc_div_t;

    // queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } ptc_qstat_t;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
        return 32'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // one quotient bit of an unsigned restoring division
    function automatic ptc_div_t div_step(input ptc_div_t s);
        ptc_div_t    r;
        logic [32:0] trial;
        logic [32:0] diff;
        r     = s;
        trial = {s.rem, s.dq[31]};
        diff  = trial - {1'b0, s.divisor};
        if (!diff[32])
        begin
            r.rem = diff[31:0];
            r.dq  = {s.dq[30:0], 1'b1};
        end
        else
        begin
            r.rem = trial[31:0];
            r.dq  = {s.dq[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== hdl/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front
// Temperature compensation and pressure pre-scaling up to the divide
// ----------------------------------------------------------------------------
module ptc_front
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ptc_coef_t   coef,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] raw_pressure,
    input  logic [19:0] raw_temperature,
    output logic        push,
    input  logic        push_ready,
    output ptc_item_t   item
);

    localparam int NSTG = 11;

    logic [NSTG-1:0] v_reg;
    logic            en;

    logic [31:0] x1_reg, d_reg;
    logic [31:0] m1_reg, m2_reg;
    logic [31:0] a3_reg, m3_reg;
    logic [31:0] pa5_reg, q5_reg;
    logic [31:0] sq6_reg, m5_6_reg, m7_6_reg;
    logic [31:0] b1_7_reg, c1_7_reg, m5_7_reg, m7_7_reg;
    logic [31:0] b8_reg, a8_reg;
    logic [31:0] a9_reg, num9_reg;
    logic [31:0] div10_reg, pn10_reg;
    logic [31:0] ap_reg [1:8];
    logic [31:0] fine_reg [4:10];
    logic [31:0] temp_reg [5:10];
    ptc_item_t   item_reg;
    ptc_item_t   item_next;
    logic [31:0] fine4_next, temp5_next;

    // whole pipe advances unless the last stage is blocked by a full queue
    assign en       = !(v_reg[NSTG-1] && !push_ready);
    assign in_ready = en;
    assign push     = v_reg[NSTG-1] && push_ready;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NSTG-2:0], in_valid};
    end

    assign fine4_next = a3_reg + asr(m3_reg, 14);
    assign temp5_next = asr((fine_reg[4] << 2) + fine_reg[4] + TEMP_ROUND, 8);

    // pick the pre-scaled dividend so that it fits in 32 bits
    always_comb
    begin
        item_next.temp     = temp_reg[10];
        item_next.fine     = fine_reg[10];
        item_next.divisor  = div10_reg;
        item_next.invalid  = (div10_reg == '0);
        item_next.dbl      = pn10_reg[31];
        item_next.dividend = pn10_reg[31] ? pn10_reg : {pn10_reg[30:0], 1'b0};
    end

    // datapath stages, one multiply deep each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= {15'd0, raw_temperature[19:3]} - {coef.t1[30:0], 1'b0};
            d_reg     <= {16'd0, raw_temperature[19:4]} - coef.t1;
            ap_reg[1] <= {12'd0, raw_pressure};

            m1_reg    <= mul32(x1_reg, coef.t2);
            m2_reg    <= mul32(d_reg, d_reg);
            ap_reg[2] <= ap_reg[1];

            a3_reg    <= asr(m1_reg, 11);
            m3_reg    <= mul32(asr(m2_reg, 12), coef.t3);
            ap_reg[3] <= ap_reg[2];

            fine_reg[4] <= fine4_next;
            ap_reg[4]   <= ap_reg[3];

            temp_reg[5] <= temp5_next;
            fine_reg[5] <= fine_reg[4];
            pa5_reg     <= asr(fine_reg[4], 1) - FINE_OFFSET;
            q5_reg      <= asr(asr(fine_reg[4], 1) - FINE_OFFSET, 2);
            ap_reg[5]   <= ap_reg[4];

            sq6_reg     <= mul32(q5_reg, q5_reg);
            m5_6_reg    <= mul32(pa5_reg, coef.p5);
            m7_6_reg    <= mul32(coef.p2, pa5_reg);
            temp_reg[6] <= temp_reg[5];
            fine_reg[6] <= fine_reg[5];
            ap_reg[6]   <= ap_reg[5];

            b1_7_reg    <= mul32(asr(sq6_reg, 11), coef.p6);
            c1_7_reg    <= mul32(coef.p3, asr(sq6_reg, 13));
            m5_7_reg    <= m5_6_reg;
            m7_7_reg    <= m7_6_reg;
            temp_reg[7] <= temp_reg[6];
            fine_reg[7] <= fine_reg[6];
            ap_reg[7]   <= ap_reg[6];

            b8_reg      <= asr(b1_7_reg + {m5_7_reg[30:0], 1'b0}, 2) + {coef.p4[15:0], 16'd0};
            a8_reg      <= asr(asr(c1_7_reg, 3) + asr(m7_7_reg, 1), 18);
            temp_reg[8] <= temp_reg[7];
            fine_reg[8] <= fine_reg[7];
            ap_reg[8]   <= ap_reg[7];

            a9_reg      <= mul32(P1_BIAS + a8_reg, coef.p1);
            num9_reg    <= (PRES_FULL - ap_reg[8]) - asr(b8_reg, 12);
            temp_reg[9] <= temp_reg[8];
            fine_reg[9] <= fine_reg[8];

            div10_reg    <= asr(a9_reg, 15);
            pn10_reg     <= mul32(num9_reg, PRES_SCALE);
            temp_reg[10] <= temp_reg[9];
            fine_reg[10] <= fine_reg[9];

            item_reg <= item_next;
        end
    end

endmodule

// ===== hdl/ptc_queue.sv =====
// ----------------------------------------------------------------------------
// ptc_queue
// Short register queue between the front and the divider side
// ----------------------------------------------------------------------------
module ptc_queue
    import ptc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ptc_item_t  push_item,
    output logic       push_ready,
    input  logic       pop,
    output ptc_item_t  pop_item,
    output ptc_qstat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ptc_item_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign push_ready = !stat.full;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hdl/ptc_back.sv =====
// ----------------------------------------------------------------------------
// ptc_back
// Pipelined divider and final pressure correction, ends in the output register
// ----------------------------------------------------------------------------
module ptc_back
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ptc_coef_t   coef,
    input  logic        in_valid,
    input  ptc_item_t   in_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] temperature_centi,
    output logic [31:0] fine_temperature,
    output logic [31:0] pressure_pa,
    output logic        pressure_invalid
);

    // divider entry, one stage per quotient bit, then four correction stages
    localparam int NSTG = DIV_STEPS + 5;

    logic [NSTG-1:0] v_reg;
    logic            en;
    ptc_div_t        div_reg [DIV_STEPS+1];
    ptc_div_t        div_next;

    logic [31:0] pa_reg, pb_p_reg, pc_reg;
    logic [31:0] sq2_reg, m8_reg;
    logic [31:0] ta_reg, tb_reg, tc_reg;
    logic [31:0] fa_reg, fb_reg, fc_reg;
    logic        ia_reg, ib_reg, ic_reg;
    logic [31:0] qa_reg, qb_reg;
    logic [31:0] temp_out_reg, fine_out_reg, pres_out_reg;
    logic        inv_out_reg;
    logic [31:0] pres_next;
    logic [31:0] q_next;
    logic [31:0] p_shr3;

    // the output register gates the whole pipe
    assign en        = !v_reg[NSTG-1] || out_ready;
    assign pop       = in_valid && en;
    assign out_valid = v_reg[NSTG-1];

    assign temperature_centi = temp_out_reg;
    assign fine_temperature  = fine_out_reg;
    assign pressure_pa       = pres_out_reg;
    assign pressure_invalid  = inv_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NSTG-2:0], in_valid};
    end

    // divider entry
    always_comb
    begin
        div_next.rem     = '0;
        div_next.dq      = in_item.dividend;
        div_next.divisor = in_item.divisor;
        div_next.temp    = in_item.temp;
        div_next.fine    = in_item.fine;
        div_next.dbl     = in_item.dbl;
        div_next.invalid = in_item.invalid;
    end

    // double the quotient when the dividend was not pre-scaled
    assign q_next    = div_reg[DIV_STEPS].dbl ? {div_reg[DIV_STEPS].dq[30:0], 1'b0}
                                              : div_reg[DIV_STEPS].dq;
    assign p_shr3    = {3'd0, pa_reg[31:3]};
    assign pres_next = pc_reg + asr(qa_reg + qb_reg + coef.p7, 4);

    // one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= div_next;
            for (int k = 0; k < DIV_STEPS; k++)
                div_reg[k+1] <= div_step(div_reg[k]);
        end
    end

    // nonlinear correction of the quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= q_next;
            ta_reg <= div_reg[DIV_STEPS].temp;
            fa_reg <= div_reg[DIV_STEPS].fine;
            ia_reg <= div_reg[DIV_STEPS].invalid;

            sq2_reg  <= mul32(p_shr3, p_shr3);
            m8_reg   <= mul32({2'd0, pa_reg[31:2]}, coef.p8);
            pb_p_reg <= pa_reg;
            tb_reg   <= ta_reg;
            fb_reg   <= fa_reg;
            ib_reg   <= ia_reg;

            qa_reg <= asr(mul32(coef.p9, {13'd0, sq2_reg[31:13]}), 12);
            qb_reg <= asr(m8_reg, 13);
            pc_reg <= pb_p_reg;
            tc_reg <= tb_reg;
            fc_reg <= fb_reg;
            ic_reg <= ib_reg;

            temp_out_reg <= tc_reg;
            fine_out_reg <= fc_reg;
            pres_out_reg <= ic_reg ? '0 : pres_next;
            inv_out_reg  <= ic_reg;
        end
    end

endmodule

// ===== hdl/pressure_temperature_compensation_top.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Integer temperature and pressure compensation of raw converter readings
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction carries a raw pressure and a raw
// temperature reading. Output stream m_*: one transaction per input with
// temperature in 0.01 degC, fine temperature and pressure in pascals;
// m_tuser flags a zero pressure divisor (pressure then reads 0).
// Calibration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no transaction is in flight, as
// the block does not enforce this. Throughput: one transaction per
// cycle while the output is not stalled. Stages from input to output:
// 11 front stages, the queue, a divider entry stage and 32 divider
// stages (one quotient bit each) and 4 correction and output stages.
// Reset clears all control state and the calibration registers; the
// queue and pipelines start empty. When m_tready is low the divider side
// holds, the queue fills, and s_tready falls once the queue is full and
// the front's last stage is occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pressure_temperature_compensation_top
    import ptc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // temperature_centi, fine_temperature, pressure_pa
    output logic        m_tuser,   // pressure_invalid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_pres_low_reg;
    logic [63:0] cal_pres_high_reg;
    logic [15:0] cal_pres_nine_reg;
    ptc_coef_t   coef;
    logic        push, push_ready, pop;
    ptc_item_t   push_item, pop_item;
    ptc_qstat_t  q_stat;
    logic [31:0] temperature_centi, fine_temperature, pressure_pa;

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg      <= '0;
            cal_pres_low_reg  <= '0;
            cal_pres_high_reg <= '0;
            cal_pres_nine_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAL_TEMP:      cal_temp_reg      <= cfg_data[47:0];
                REG_CAL_PRES_LOW:  cal_pres_low_reg  <= cfg_data;
                REG_CAL_PRES_HIGH: cal_pres_high_reg <= cfg_data;
                REG_CAL_PRES_NINE: cal_pres_nine_reg <= cfg_data[15:0];
                default:           cal_temp_reg      <= cal_temp_reg;
            endcase
        end
    end

    // coefficient unpacking
    always_comb
    begin
        coef.t1 = {16'd0, cal_temp_reg[15:0]};
        coef.t2 = sext16(cal_temp_reg[31:16]);
        coef.t3 = sext16(cal_temp_reg[47:32]);
        coef.p1 = {16'd0, cal_pres_low_reg[15:0]};
        coef.p2 = sext16(cal_pres_low_reg[31:16]);
        coef.p3 = sext16(cal_pres_low_reg[47:32]);
        coef.p4 = sext16(cal_pres_low_reg[63:48]);
        coef.p5 = sext16(cal_pres_high_reg[15:0]);
        coef.p6 = sext16(cal_pres_high_reg[31:16]);
        coef.p7 = sext16(cal_pres_high_reg[47:32]);
        coef.p8 = sext16(cal_pres_high_reg[63:48]);
        coef.p9 = sext16(cal_pres_nine_reg);
    end

    ptc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef            (coef),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .raw_pressure    (s_tdata[19:0]),
        .raw_temperature (s_tdata[39:20]),
        .push            (push),
        .push_ready      (push_ready),
        .item            (push_item)
    );

    ptc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_item   (pop_item),
        .stat       (q_stat)
    );

    ptc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .coef              (coef),
        .in_valid          (!q_stat.empty),
        .in_item           (pop_item),
        .pop               (pop),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .temperature_centi (temperature_centi),
        .fine_temperature  (fine_temperature),
        .pressure_pa       (pressure_pa),
        .pressure_invalid  (m_tuser)
    );

    assign m_tdata = {pressure_pa, fine_temperature, temperature_centi};

    // checks
    `ASSERT_ALWAYS(a_queue_state, !(q_stat.full && q_stat.empty), "queue full and empty")
    `ASSERT_IMPLY(a_invalid_zero, m_tvalid && m_tuser, m_tdata[95:64] == '0, "invalid nonzero")
    `ASSERT_IMPLY(a_stall_full, !s_tready, q_stat.full, "front stalled with room in queue")

endmodule
